// ----- sv/keyword_color_classifier_defines.svh -----
// assertion macros for the keyword color classifier checker
`ifndef KEYWORD_COLOR_CLASSIFIER_DEFINES_SVH
`define KEYWORD_COLOR_CLASSIFIER_DEFINES_SVH

// consequent in the cycle after the antecedent, off while in reset
`define KCC_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent, also checked through reset
`define KCC_ASSERT_AFTER_RESET(label, ante, cons, msg) \
label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/kcc_pkg.sv -----
package kcc_pkg;

    // line and window sizing
    localparam int LINE_MAX  = 256;
    localparam int LOOKAHEAD = 9;
    localparam logic [7:0] COL_CAP = 8'((LINE_MAX - 1 < 255) ? LINE_MAX - 1 : 255);
    localparam int FILL_W    = $clog2(LOOKAHEAD + 1);

    // longest keyword decides the width of one match
    localparam int KW_MAX = 9;
    localparam int LEN_W  = $clog2(KW_MAX + 1);
    localparam int IDX_W  = $clog2(KW_MAX);

    // match queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CLS_BRACKET = 3'd0,
        CLS_DECL    = 3'd1,
        CLS_STRING  = 3'd2,
        CLS_DEFAULT = 3'd3,
        CLS_COMMENT = 3'd4,
        CLS_RETURN  = 3'd5,
        CLS_INCLUDE = 3'd6
    } t_color_class;

    // one decided match: up to KW_MAX bytes sharing one class
    typedef struct packed {
        logic [KW_MAX-1:0][7:0] bytes;
        logic [7:0]             head_col;
        t_color_class           cls;
        logic [LEN_W-1:0]       len;
        logic                   last;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- sv/kcc_queue.sv -----
module kcc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kcc_pkg::t_run    i_push_run,
    input  logic             i_pop,
    output kcc_pkg::t_run    o_head,
    output kcc_pkg::t_q_stat o_stat
);
    import kcc_pkg::*;

    t_run              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_run;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ----- sv/kcc_front.sv -----
module kcc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_start_column,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_text_byte,
    input  logic             i_line_end,
    input  kcc_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output kcc_pkg::t_run    o_push_run
);
    import kcc_pkg::*;

    typedef logic [LOOKAHEAD-1:0][7:0] t_win;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_FLUSH = 2'b10
    } t_fstate;

    // keywords, right-aligned, first character in the highest of the keyword's bytes
    localparam logic [8*KW_MAX-1:0] KW_INT       = "int";
    localparam logic [8*KW_MAX-1:0] KW_STRING    = "string";
    localparam logic [8*KW_MAX-1:0] KW_CHAR      = "char";
    localparam logic [8*KW_MAX-1:0] KW_BOOL      = "bool";
    localparam logic [8*KW_MAX-1:0] KW_VOID      = "void";
    localparam logic [8*KW_MAX-1:0] KW_WHILE     = "while";
    localparam logic [8*KW_MAX-1:0] KW_FOR       = "for";
    localparam logic [8*KW_MAX-1:0] KW_IF        = "if";
    localparam logic [8*KW_MAX-1:0] KW_ELSE      = "else";
    localparam logic [8*KW_MAX-1:0] KW_RETURN    = "return";
    localparam logic [8*KW_MAX-1:0] KW_PUBLIC    = "public";
    localparam logic [8*KW_MAX-1:0] KW_PRIVATE   = "private";
    localparam logic [8*KW_MAX-1:0] KW_PROTECTED = "protected";
    localparam logic [8*KW_MAX-1:0] KW_CLASS     = "class";
    localparam logic [8*KW_MAX-1:0] KW_INCLUDE   = "#include";
    localparam logic [8*KW_MAX-1:0] KW_BLOCK_CMT = "/*";
    localparam logic [8*KW_MAX-1:0] KW_LINE_CMT  = "//";

    // word of len characters sits at the window head
    function automatic logic head_is(input t_win w, input logic [FILL_W-1:0] fill,
                                     input logic [8*KW_MAX-1:0] word, input int len);
        logic ok;
        ok = (len <= int'(fill));
        for (int i = 0; i < KW_MAX; i++) begin
            if (i < len) begin
                if (w[i] != word[8*(len-1-i) +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    t_fstate           r_state, n_state;
    t_win              r_win, n_win;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_head, n_head;
    logic [7:0]        r_prev, n_prev;
    logic              r_str, n_str;
    logic              r_cmt, n_cmt;
    logic [7:0]        r_col, n_col;

    logic              in_accept;
    logic              take;
    t_win              w_app;
    logic [FILL_W-1:0] fill_a;
    logic [7:0]        head_a;
    logic [7:0]        prev_a;
    logic [7:0]        col_inc;

    t_win              dw;
    logic [FILL_W-1:0] dfill;
    logic [7:0]        dhead;
    logic [7:0]        dprev;
    logic              dflush;
    logic [7:0]        head_b;

    logic [LEN_W-1:0]  d_len;
    t_color_class      d_cls;
    logic              tog_s;
    logic              tog_c;
    logic              set_c;

    logic [LOOKAHEAD+KW_MAX-1:0][7:0] ext;
    t_win              s_win;
    logic [FILL_W-1:0] fill_s;
    logic [8:0]        hsum;
    logic [7:0]        head_s;
    logic [7:0]        prev_s;
    logic              str_s;
    logic              cmt_s;

    assign o_in_stall = (r_state == ST_FLUSH) || i_q_stat.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    // append the incoming byte to the window once its column reaches the start column
    always_comb begin
        take = (r_col >= i_start_column);
        for (int k = 0; k < LOOKAHEAD; k++) begin
            w_app[k] = (take && (FILL_W'(k) == r_fill)) ? i_text_byte : r_win[k];
        end
        fill_a  = r_fill + FILL_W'(take);
        head_a  = (r_fill == '0) ? r_col : r_head;
        prev_a  = take ? r_prev : i_text_byte;
        col_inc = (r_col < COL_CAP) ? r_col + 8'd1 : r_col;
    end

    // window seen by the match logic
    always_comb begin
        dflush = (r_state == ST_FLUSH);
        if (dflush) begin
            dw    = r_win;
            dfill = r_fill;
            dhead = r_head;
            dprev = r_prev;
        end else begin
            dw    = w_app;
            dfill = fill_a;
            dhead = head_a;
            dprev = prev_a;
        end
        head_b = dw[0];
    end

    // match at the window head in priority order
    always_comb begin
        d_len = LEN_W'(1);
        d_cls = CLS_DEFAULT;
        tog_s = 1'b0;
        tog_c = 1'b0;
        set_c = 1'b0;
        if (head_b == "{" || head_b == "}" || head_b == "(" || head_b == ")"
                || head_b == "[" || head_b == "]") begin
            d_cls = CLS_BRACKET;
        end else if (head_is(dw, dfill, KW_INT, 3) && (dhead == 8'd0 || dprev == " ")) begin
            d_len = LEN_W'(3);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_STRING, 6)) begin
            d_len = LEN_W'(6);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_CHAR, 4) || head_is(dw, dfill, KW_BOOL, 4)
                || head_is(dw, dfill, KW_VOID, 4)) begin
            d_len = LEN_W'(4);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_WHILE, 5)) begin
            d_len = LEN_W'(5);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_FOR, 3)) begin
            d_len = LEN_W'(3);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_IF, 2)) begin
            d_len = LEN_W'(2);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_ELSE, 4)) begin
            d_len = LEN_W'(4);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_RETURN, 6)) begin
            d_len = LEN_W'(6);
            d_cls = CLS_RETURN;
        end else if (head_b == "\"") begin
            tog_s = 1'b1;
            d_cls = CLS_STRING;
        end else if (head_is(dw, dfill, KW_PUBLIC, 6)) begin
            d_len = LEN_W'(6);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_PRIVATE, 7)) begin
            d_len = LEN_W'(7);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_PROTECTED, 9)) begin
            d_len = LEN_W'(9);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_CLASS, 5)) begin
            d_len = LEN_W'(5);
            d_cls = CLS_DECL;
        end else if (head_is(dw, dfill, KW_INCLUDE, 8)) begin
            d_len = LEN_W'(8);
            d_cls = CLS_INCLUDE;
        end else if (head_is(dw, dfill, KW_BLOCK_CMT, 2)) begin
            tog_c = 1'b1;
            d_len = LEN_W'(2);
            d_cls = CLS_COMMENT;
        end else if (head_is(dw, dfill, KW_LINE_CMT, 2)) begin
            set_c = 1'b1;
            d_len = LEN_W'(2);
            d_cls = CLS_COMMENT;
        end else if (r_str) begin
            d_cls = CLS_STRING;
        end else if (r_cmt) begin
            d_cls = CLS_COMMENT;
        end else begin
            d_cls = CLS_DEFAULT;
        end
    end

    // window and context after the match is taken out
    always_comb begin
        ext = {{KW_MAX{8'h00}}, dw};
        prev_s = dw[0];
        for (int j = 1; j <= KW_MAX; j++) begin
            if (d_len == LEN_W'(j)) begin
                prev_s = ext[j-1];
            end
        end
        for (int k = 0; k < LOOKAHEAD; k++) begin
            s_win[k] = 8'h00;
            for (int j = 1; j <= KW_MAX; j++) begin
                if (d_len == LEN_W'(j)) begin
                    s_win[k] = ext[k+j];
                end
            end
        end
        fill_s = dfill - FILL_W'(d_len);
        hsum   = {1'b0, dhead} + 9'(d_len);
        head_s = (hsum > {1'b0, COL_CAP}) ? COL_CAP : hsum[7:0];
        str_s  = r_str ^ tog_s;
        cmt_s  = set_c | (r_cmt ^ tog_c);
    end

    // match word toward the queue
    always_comb begin
        for (int i = 0; i < KW_MAX; i++) begin
            o_push_run.bytes[i] = dw[i];
        end
        o_push_run.head_col = dhead;
        o_push_run.cls      = d_cls;
        o_push_run.len      = d_len;
        o_push_run.last     = dflush && (dfill == FILL_W'(d_len));
    end

    // front sequencer
    always_comb begin
        n_state = r_state;
        n_win   = r_win;
        n_fill  = r_fill;
        n_head  = r_head;
        n_prev  = r_prev;
        n_str   = r_str;
        n_cmt   = r_cmt;
        n_col   = r_col;
        o_push  = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (in_accept) begin
                    n_col = col_inc;
                    if (i_line_end) begin
                        if (fill_a == '0) begin
                            n_win  = '0;
                            n_fill = '0;
                            n_head = '0;
                            n_prev = '0;
                            n_str  = 1'b0;
                            n_cmt  = 1'b0;
                            n_col  = '0;
                        end else begin
                            n_win   = w_app;
                            n_fill  = fill_a;
                            n_head  = head_a;
                            n_prev  = prev_a;
                            n_state = ST_FLUSH;
                        end
                    end else if (fill_a == FILL_W'(LOOKAHEAD)) begin
                        o_push = 1'b1;
                        n_win  = s_win;
                        n_fill = fill_s;
                        n_head = head_s;
                        n_prev = prev_s;
                        n_str  = str_s;
                        n_cmt  = cmt_s;
                    end else begin
                        n_win  = w_app;
                        n_fill = fill_a;
                        n_head = head_a;
                        n_prev = prev_a;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_q_stat.full) begin
                    o_push = 1'b1;
                    if (fill_s == '0) begin
                        n_win   = '0;
                        n_fill  = '0;
                        n_head  = '0;
                        n_prev  = '0;
                        n_str   = 1'b0;
                        n_cmt   = 1'b0;
                        n_col   = '0;
                        n_state = ST_RUN;
                    end else begin
                        n_win  = s_win;
                        n_fill = fill_s;
                        n_head = head_s;
                        n_prev = prev_s;
                        n_str  = str_s;
                        n_cmt  = cmt_s;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // front state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_win   <= '0;
            r_fill  <= '0;
            r_head  <= '0;
            r_prev  <= '0;
            r_str   <= 1'b0;
            r_cmt   <= 1'b0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_win   <= n_win;
            r_fill  <= n_fill;
            r_head  <= n_head;
            r_prev  <= n_prev;
            r_str   <= n_str;
            r_cmt   <= n_cmt;
            r_col   <= n_col;
        end
    end

endmodule

// ----- sv/kcc_back.sv -----
module kcc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kcc_pkg::t_run    i_head,
    input  kcc_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic [7:0]       o_out_column,
    output logic [2:0]       o_color_class,
    output logic             o_last_of_line
);
    import kcc_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [7:0]       r_byte;
    logic [7:0]       r_col;
    t_color_class     r_cls;
    logic             r_last;

    logic             advance;
    logic             take;
    logic             idx_last;
    logic [8:0]       csum;
    logic [7:0]       col;

    // step through the match at the queue head, one byte per word
    always_comb begin
        advance  = !r_out_valid || !i_out_stall;
        take     = advance && !i_q_stat.empty;
        idx_last = (r_idx == IDX_W'(i_head.len - LEN_W'(1)));
        o_pop    = take && idx_last;
        csum     = {1'b0, i_head.head_col} + 9'(r_idx);
        col      = (csum > {1'b0, COL_CAP}) ? COL_CAP : csum[7:0];
    end

    // byte index within the current match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_idx       <= idx_last ? '0 : r_idx + IDX_W'(1);
            r_out_valid <= 1'b1;
        end else if (advance) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_head.bytes[r_idx];
            r_col  <= col;
            r_cls  <= i_head.cls;
            r_last <= i_head.last && idx_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_byte;
    assign o_out_column   = r_col;
    assign o_color_class  = r_cls;
    assign o_last_of_line = r_last;

endmodule

// ----- sv/keyword_color_classifier.sv -----
// Colors one line of source text per pass: bytes enter one per cycle while
// o_in_stall is low, and each byte from the start column on leaves once with
// its column and color class (0 bracket, 1 declaration, 2 string, 3 default,
// 4 comment, 5 return, 6 include), in order, with last_of_line on the final
// byte of the line. A byte is classified when eight more bytes of the same
// line have arrived or the line ends, since matches are decided on a nine-byte
// window; the match logic compares the whole window combinationally, so input
// runs at one byte per cycle unless stalled and output at one word per cycle
// while unstalled out of a four-entry match queue. After a byte with line_end
// set is taken, the input is held off while the matches still in the window
// are drained, not at all for a line that left no bytes to color, and also
// while the queue is full. The first word of a match passes through the
// match queue and the output word register after the byte that fills the
// window; at a line end the window is registered first and the matches are
// drained from it in the flush state. Words wait while the queue holds older
// words or the output is stalled.
// The start column is to be written by the user only while the block is idle
// (the block does not enforce this); lines shorter than it give no results.
module keyword_color_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [7:0] o_out_column,
    output logic [2:0] o_color_class,
    output logic       o_last_of_line,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import kcc_pkg::*;

    logic [7:0] r_start_column;
    logic       push;
    t_run       push_run;
    logic       pop;
    t_run       head_run;
    t_q_stat    q_stat;

    // start column register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_column <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_start_column <= i_cfg_data;
        end
    end

    // window and match decision
    kcc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_column (r_start_column),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_line_end     (i_line_end),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_push_run     (push_run)
    );

    // decided matches waiting for output
    kcc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_run (push_run),
        .i_pop      (pop),
        .o_head     (head_run),
        .o_stat     (q_stat)
    );

    // per-byte output
    kcc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_run),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_out_column   (o_out_column),
        .o_color_class  (o_color_class),
        .o_last_of_line (o_last_of_line)
    );

endmodule

// ----- sv/kcc_checker.sv -----
`include "keyword_color_classifier_defines.svh"

module kcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_text_byte,
    input logic       i_line_end,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic [7:0] o_out_column,
    input logic [2:0] o_color_class,
    input logic       o_last_of_line,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic [7:0] i_cfg_data
);
    import kcc_pkg::*;

    // reset leaves no word pending and the input open
    `KCC_ASSERT_AFTER_RESET(a_reset_quiet, !i_rst_n, !o_out_valid && !o_in_stall, "not idle after reset")

    // a stalled output word holds
    `KCC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte) && $stable(o_out_column) && $stable(o_color_class) && $stable(o_last_of_line), "stalled output word changed")

    // within a line the next word sits one column further, saturating
    `KCC_ASSERT_NEXT(a_col_step, o_out_valid && !i_out_stall && !o_last_of_line, !o_out_valid || (o_out_column == $past(o_out_column) + 8'd1) || ($past(o_out_column) == COL_CAP && o_out_column == COL_CAP), "column did not advance within the line")

endmodule

bind keyword_color_classifier kcc_checker u_kcc_checker (.*);

// ----- tb/keyword_color_classifier_tb.sv -----
`timescale 1ns / 100ps

module keyword_color_classifier_tb;
    import kcc_pkg::*;

    localparam int RUN_LIMIT  = 300000;
    localparam int DRAIN_WAIT = 20;
    localparam int KW_COUNT   = 15;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_line_end = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic [7:0] o_out_column;
    logic [2:0] o_color_class;
    logic       o_last_of_line;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = 8'h00;

    keyword_color_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_line_end     (i_line_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_out_column   (o_out_column),
        .o_color_class  (o_color_class),
        .o_last_of_line (o_last_of_line),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // one colored output word
    typedef struct {
        logic [7:0]   ch;
        logic [7:0]   col;
        t_color_class cls;
        logic         last;
    } colored_t;

    // one directed input word, with a hand-written result for one-byte lines
    typedef struct {
        logic [7:0]   ch;
        logic         eol;
        bit           typed;
        t_color_class cls;
    } text_row_t;

    colored_t    colored_due[$];
    colored_t    fresh_colors[$];
    logic [7:0]  line_buf[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          sent_words = 0;
    bit          calm = 1'b0;

    // classifier shadow state
    logic [7:0]  win_bytes [LOOKAHEAD];
    int          win_fill;
    logic [7:0]  byte_before;
    bit          str_on;
    bit          cmt_on;
    logic [7:0]  next_col;
    logic [7:0]  head_col;
    logic [7:0]  first_col;

    string kw_list [KW_COUNT] = '{"int", "string", "char", "bool", "void", "while", "for",
        "if", "else", "return", "public", "private", "protected", "class", "#include"};
    string cmt_marks [3] = '{"/*", "*/", "//"};
    string brackets = "{}()[]";

    text_row_t directed_rows [23] = '{
        '{"{",   1'b1, 1'b1, CLS_BRACKET},
        '{")",   1'b1, 1'b1, CLS_BRACKET},
        '{"\"",  1'b1, 1'b1, CLS_STRING},
        '{8'h00, 1'b1, 1'b1, CLS_DEFAULT},
        '{8'hff, 1'b1, 1'b1, CLS_DEFAULT},
        '{"/",   1'b1, 1'b1, CLS_DEFAULT},
        // line comment runs to the line end
        '{"/", 1'b0, 1'b0, CLS_DEFAULT},
        '{"/", 1'b0, 1'b0, CLS_DEFAULT},
        '{"x", 1'b1, 1'b0, CLS_DEFAULT},
        // open string cut by the line end
        '{"\"", 1'b0, 1'b0, CLS_DEFAULT},
        '{"a",  1'b1, 1'b0, CLS_DEFAULT},
        // full nine-letter keyword filling the window
        '{"p", 1'b0, 1'b0, CLS_DEFAULT},
        '{"r", 1'b0, 1'b0, CLS_DEFAULT},
        '{"o", 1'b0, 1'b0, CLS_DEFAULT},
        '{"t", 1'b0, 1'b0, CLS_DEFAULT},
        '{"e", 1'b0, 1'b0, CLS_DEFAULT},
        '{"c", 1'b0, 1'b0, CLS_DEFAULT},
        '{"t", 1'b0, 1'b0, CLS_DEFAULT},
        '{"e", 1'b0, 1'b0, CLS_DEFAULT},
        '{"d", 1'b1, 1'b0, CLS_DEFAULT},
        '{"i", 1'b0, 1'b0, CLS_DEFAULT},
        '{"f", 1'b0, 1'b0, CLS_DEFAULT},
        '{"(", 1'b1, 1'b0, CLS_DEFAULT}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("keyword_color_classifier_tb: errors");
            $finish;
        end
    end

    // output stall
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 30);
    end

    function automatic void clear_line();
        for (int i = 0; i < LOOKAHEAD; i++) win_bytes[i] = 8'h00;
        win_fill    = 0;
        byte_before = 8'h00;
        str_on      = 1'b0;
        cmt_on      = 1'b0;
        next_col    = 8'd0;
        head_col    = 8'd0;
    endfunction

    function automatic bit window_starts(string w);
        if (w.len() > win_fill) return 1'b0;
        for (int i = 0; i < w.len(); i++)
            if (win_bytes[i] != w[i]) return 1'b0;
        return 1'b1;
    endfunction

    // decide one match at the window head and emit its bytes
    function automatic void color_head(bit flushing);
        int           len;
        t_color_class cls;
        logic [7:0]   b;
        colored_t     w;
        len = 1;
        b   = win_bytes[0];
        if (b == "{" || b == "}" || b == "(" || b == ")" || b == "[" || b == "]") begin
            cls = CLS_BRACKET;
        end else if (window_starts("int") && (head_col == 0 || byte_before == " ")) begin
            len = 3; cls = CLS_DECL;
        end else if (window_starts("string")) begin
            len = 6; cls = CLS_DECL;
        end else if (window_starts("char") || window_starts("bool") || window_starts("void")) begin
            len = 4; cls = CLS_DECL;
        end else if (window_starts("while")) begin
            len = 5; cls = CLS_DECL;
        end else if (window_starts("for")) begin
            len = 3; cls = CLS_DECL;
        end else if (window_starts("if")) begin
            len = 2; cls = CLS_DECL;
        end else if (window_starts("else")) begin
            len = 4; cls = CLS_DECL;
        end else if (window_starts("return")) begin
            len = 6; cls = CLS_RETURN;
        end else if (b == "\"") begin
            str_on = !str_on;
            cls = CLS_STRING;
        end else if (window_starts("public")) begin
            len = 6; cls = CLS_DECL;
        end else if (window_starts("private")) begin
            len = 7; cls = CLS_DECL;
        end else if (window_starts("protected")) begin
            len = 9; cls = CLS_DECL;
        end else if (window_starts("class")) begin
            len = 5; cls = CLS_DECL;
        end else if (window_starts("#include")) begin
            len = 8; cls = CLS_INCLUDE;
        end else if (window_starts("/*")) begin
            cmt_on = !cmt_on;
            len = 2; cls = CLS_COMMENT;
        end else if (window_starts("//")) begin
            cmt_on = 1'b1;
            len = 2; cls = CLS_COMMENT;
        end else if (str_on) begin
            cls = CLS_STRING;
        end else if (cmt_on) begin
            cls = CLS_COMMENT;
        end else begin
            cls = CLS_DEFAULT;
        end

        for (int i = 0; i < len; i++) begin
            w.ch   = win_bytes[i];
            w.col  = head_col;
            w.cls  = cls;
            w.last = flushing && (i + 1 == len) && (len == win_fill);
            fresh_colors.push_back(w);
            if (head_col < COL_CAP) head_col++;
        end
        byte_before = win_bytes[len-1];
        for (int i = 0; i + len < LOOKAHEAD; i++) win_bytes[i] = win_bytes[i+len];
        win_fill -= len;
    endfunction

    // shadow of one accepted text byte
    function automatic void color_text_byte(logic [7:0] b, logic eol);
        if (next_col >= first_col) begin
            if (win_fill == 0) head_col = next_col;
            win_bytes[win_fill] = b;
            win_fill++;
        end else begin
            byte_before = b;
        end
        if (next_col < COL_CAP) next_col++;
        if (eol) begin
            while (win_fill > 0) color_head(1'b1);
            clear_line();
        end else if (win_fill >= LOOKAHEAD) begin
            color_head(1'b0);
        end
    endfunction

    // check each accepted output word against the oldest expected one
    always @(posedge i_clk) begin
        colored_t exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (colored_due.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual byte %h col %0d class %0d",
                         $time, o_out_byte, o_out_column, o_color_class);
                error_count++;
            end else begin
                exp_w = colored_due.pop_front();
                if (o_out_byte !== exp_w.ch) begin
                    $display("%0t: byte mismatch: expected %h, actual %h",
                             $time, exp_w.ch, o_out_byte);
                    error_count++;
                end
                if (o_out_column !== exp_w.col) begin
                    $display("%0t: column mismatch: expected %0d, actual %0d",
                             $time, exp_w.col, o_out_column);
                    error_count++;
                end
                if (o_color_class !== exp_w.cls) begin
                    $display("%0t: class mismatch: expected %0d, actual %0d",
                             $time, exp_w.cls, o_color_class);
                    error_count++;
                end
                if (o_last_of_line !== exp_w.last) begin
                    $display("%0t: last_of_line mismatch: expected %0d, actual %0d",
                             $time, exp_w.last, o_last_of_line);
                    error_count++;
                end
            end
        end
    end

    // send one text word; valid stays high into the next word unless the bench idles first
    task automatic send_word(logic [7:0] b, logic eol, bit typed = 1'b0,
                             t_color_class cls = CLS_DEFAULT);
        colored_t w;
        while (!calm && $urandom_range(0, 99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        i_line_end  <= eol;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_words++;
        color_text_byte(b, eol);
        // one-byte line with a hand-written result
        if (typed) begin
            fresh_colors.delete();
            w.ch   = b;
            w.col  = 8'd0;
            w.cls  = cls;
            w.last = 1'b1;
            fresh_colors.push_back(w);
        end
        while (fresh_colors.size() > 0) colored_due.push_back(fresh_colors.pop_front());
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    // build a line of mostly well-formed tokens with some noise and send it
    task automatic send_random_line(int target);
        int    pick;
        string w;
        line_buf.delete();
        while (line_buf.size() < target) begin
            pick = $urandom_range(0, 99);
            w = kw_list[$urandom_range(0, KW_COUNT - 1)];
            if (pick < 35) begin
                add_text(w);
            end else if (pick < 43) begin
                // broken keyword
                add_text(w.substr(0, w.len() - 2));
            end else if (pick < 53) begin
                line_buf.push_back(brackets[$urandom_range(0, 5)]);
            end else if (pick < 60) begin
                line_buf.push_back("\"");
            end else if (pick < 68) begin
                add_text(cmt_marks[$urandom_range(0, 2)]);
            end else if (pick < 80) begin
                line_buf.push_back(" ");
            end else if (pick < 90) begin
                line_buf.push_back(8'($urandom_range(97, 122)));
            end else begin
                line_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        while (line_buf.size() > target) void'(line_buf.pop_back());
        foreach (line_buf[i]) send_word(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic run_lines(int goal, int max_len);
        int stop_at;
        stop_at = sent_words + goal;
        while (sent_words < stop_at) send_random_line($urandom_range(1, max_len));
    endtask

    // stop input, let all expected words arrive and the block go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (colored_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_start_column(logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        first_col = v;
    endtask

    initial begin
        first_col = 8'd0;
        clear_line();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines
        foreach (directed_rows[i])
            send_word(directed_rows[i].ch, directed_rows[i].eol,
                      directed_rows[i].typed, directed_rows[i].cls);
        run_lines(65, 24);
        settle();

        // skip the first four columns, no idling on either side
        calm = 1'b1;
        write_start_column(8'd4);
        run_lines(35, 20);
        settle();
        calm = 1'b0;

        // highest start column: short lines with no words
        write_start_column(8'd255);
        run_lines(8, 8);
        settle();

        write_start_column(8'd0);
        run_lines(40, 30);
        settle();

        write_start_column(8'($urandom_range(1, 12)));
        run_lines(25, 20);
        settle();

        if (error_count == 0) begin
            $display("keyword_color_classifier_tb: clean");
        end else begin
            $display("keyword_color_classifier_tb: errors");
        end
        $finish;
    end

endmodule
